FILE: rtl/abe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES block encryption package
// Shared widths, register indexes, the S-box and the round helper functions.
// ----------------------------------------------------------------------------
package abe_pkg;

  localparam int unsigned KeyStoreWords = 60;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 64;

  localparam logic [CfgIdxW-1:0] RegKeySize  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyWord0 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeyWord1 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyWord2 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKeyWord3 = 3'd4;

  localparam logic [1:0] KeySize128 = 2'd0;
  localparam logic [1:0] KeySize192 = 2'd1;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_column(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24];
    a1 = w[23:16];
    a2 = w[15:8];
    a3 = w[7:0];
    mix_column = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                  a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                  a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                  xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // SubBytes and ShiftRows over the whole state, four columns of 32 bits.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [31:0] c [4];
    logic [127:0] r;
    for (int i = 0; i < 4; i++) begin
      c[i] = s[127-32*i -: 32];
    end
    r = '0;
    for (int i = 0; i < 4; i++) begin
      r[127-32*i -: 32] = sub_word({c[i][31:24], c[(i+1)%4][23:16],
                                    c[(i+2)%4][15:8], c[(i+3)%4][7:0]});
    end
    sub_shift = r;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    mix_columns = {mix_column(s[127:96]), mix_column(s[95:64]),
                   mix_column(s[63:32]), mix_column(s[31:0])};
  endfunction

endpackage

FILE: rtl/abe_key_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES key expansion
// Produces one expanded key word per cycle from a sliding window of the last
// eight words; the top level writes each word into the round-key memory.
// ----------------------------------------------------------------------------
module abe_key_expand (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  key_size_i,
  input  logic [255:0] key_i,
  output logic        word_valid_o,
  output logic [5:0]  word_idx_o,
  output logic [31:0] word_o,
  output logic        done_o
);

  logic        run_q, run_d;
  logic [5:0]  idx_q, idx_d;
  logic [3:0]  nk;
  logic [5:0]  total;
  logic [2:0]  pos_q, pos_d;      // idx mod nk
  logic [7:0]  rcon_q, rcon_d;
  logic [31:0] win_q [8];
  logic [31:0] win_d [8];
  logic [31:0] t, prev, old, w;
  logic        done_q, done_d;

  always_comb begin
    case (key_size_i)
      abe_pkg::KeySize128: nk = 4'd4;
      abe_pkg::KeySize192: nk = 4'd6;
      default:             nk = 4'd8;
    endcase
    total = 6'(4 * (nk + 4'd7));
  end

  // The window holds w[i-8..i-1], newest at index 7.
  always_comb begin
    prev = win_q[7];
    old  = win_q[3'(4'd8 - nk)];
    t    = prev;
    if (idx_q < 6'(nk)) begin
      w = key_i[255 - 32*idx_q[2:0] -: 32];
    end else begin
      if (pos_q == 3'd0) begin
        t = abe_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rcon_q, 24'h0};
      end else if (nk == 4'd8 && pos_q == 3'd4) begin
        t = abe_pkg::sub_word(prev);
      end
      w = old ^ t;
    end
  end

  always_comb begin
    run_d  = run_q;
    idx_d  = idx_q;
    pos_d  = pos_q;
    rcon_d = rcon_q;
    done_d = 1'b0;
    for (int i = 0; i < 8; i++) begin
      win_d[i] = win_q[i];
    end
    if (start_i) begin
      run_d  = 1'b1;
      idx_d  = '0;
      pos_d  = '0;
      rcon_d = 8'h01;
    end else if (run_q) begin
      for (int i = 0; i < 7; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[7] = w;
      if (idx_q >= 6'(nk) && pos_q == 3'd0) begin
        rcon_d = abe_pkg::xtime(rcon_q);
      end
      pos_d = (4'(pos_q) + 4'd1 == nk) ? 3'd0 : pos_q + 3'd1;
      idx_d = idx_q + 6'd1;
      if (idx_q == total - 6'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
      pos_q  <= '0;
      rcon_q <= 8'h01;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      idx_q  <= idx_d;
      pos_q  <= pos_d;
      rcon_q <= rcon_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) begin
      win_q[i] <= win_d[i];
    end
  end

  assign word_valid_o = run_q;
  assign word_idx_o   = idx_q;
  assign word_o       = w;
  assign done_o       = done_q;

endmodule

FILE: rtl/aes_block_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES block encryption, 128/192/256-bit keys
// Encrypts one 128-bit block per start using round keys from an internal store.
// ----------------------------------------------------------------------------
// A block is accepted when start_i is high while busy_o is low. Its result
// appears on cipher_high_o/cipher_low_o for exactly one cycle with done_o high,
// and the receiver cannot stall it, so it must take the transfer in that cycle.
// Each block runs its rounds at one AES round per cycle, paced by the single
// read port of the round-key memory, which delivers one 128-bit round key
// per cycle through a registered read. The first block after reset or after
// any write to the key-size or key-word registers first expands the key into
// that memory, one 32-bit word per cycle, before its rounds begin.
// Configuration must be written only while busy_o is low; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module aes_block_encrypt #(
  parameter int unsigned KEY_STORE_WORDS = abe_pkg::KeyStoreWords
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [abe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [abe_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [63:0]                  text_high_i,
  input  logic [63:0]                  text_low_i,
  output logic                         done_o,
  output logic [63:0]                  cipher_high_o,
  output logic [63:0]                  cipher_low_o
);

  // The memory holds one round key of four words per row.
  localparam int unsigned Rows  = (KEY_STORE_WORDS + 3) / 4;
  localparam int unsigned RowW  = (Rows > 1) ? $clog2(Rows) : 1;

  typedef enum logic [2:0] {
    StIdle, StExpand, StLoad, StRound, StOut
  } state_e;

  state_e      state_q;
  logic [1:0]  key_size_q;
  logic [63:0] key_q [4];
  logic        keys_ready_q;
  logic [127:0] st_q;
  logic [3:0]  round_q;
  logic [3:0]  nr;
  logic        done_q;

  // Round-key memory: word-enabled writes during expansion, row reads later.
  logic [31:0]  mem [Rows][4];
  logic [127:0] rk_q;
  logic         rk_ok_q;
  logic [3:0]   rd_row;
  logic         rd_ok;

  logic        kx_start, kx_valid, kx_done;
  logic [5:0]  kx_idx;
  logic [31:0] kx_word;
  logic [127:0] st_sub, st_next;

  always_comb begin
    case (key_size_q)
      abe_pkg::KeySize128: nr = 4'd10;
      abe_pkg::KeySize192: nr = 4'd12;
      default:             nr = 4'd14;
    endcase
  end

  assign kx_start = (state_q == StIdle) && start_i && !keys_ready_q;

  abe_key_expand u_kx (
    .clk_i,
    .rst_ni,
    .start_i     (kx_start),
    .key_size_i  (key_size_q),
    .key_i       ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .word_valid_o(kx_valid),
    .word_idx_o  (kx_idx),
    .word_o      (kx_word),
    .done_o      (kx_done)
  );

  // Rows beyond the store read as zero. The load cycle fetches round key 1,
  // and round r fetches the key for round r + 1.
  always_comb begin
    if (state_q == StRound) begin
      rd_row = round_q + 4'd1;
    end else if (state_q == StLoad) begin
      rd_row = 4'd1;
    end else begin
      rd_row = 4'd0;
    end
    rd_ok = (32'(rd_row) * 4 + 3 < KEY_STORE_WORDS) || (32'(rd_row) < Rows &&
            32'(rd_row) * 4 < KEY_STORE_WORDS);
  end

  always_ff @(posedge clk_i) begin
    if (kx_valid && 32'(kx_idx) < KEY_STORE_WORDS) begin
      mem[RowW'(kx_idx[5:2])][kx_idx[1:0]] <= kx_word;
    end
    if (rd_ok) begin
      rk_q <= {mem[RowW'(rd_row)][0], mem[RowW'(rd_row)][1],
               mem[RowW'(rd_row)][2], mem[RowW'(rd_row)][3]};
    end
    rk_ok_q <= rd_ok;
  end

  // Row index of the key currently in rk_q.
  logic [3:0] round_last_q;
  always_ff @(posedge clk_i) begin
    round_last_q <= rd_row;
  end

  // A partial last row only exists when the store is not a multiple of four.
  logic [127:0] rk;
  always_comb begin
    rk = rk_ok_q ? rk_q : '0;
    for (int c = 0; c < 4; c++) begin
      if (32'(round_last_q) * 4 + c >= KEY_STORE_WORDS) begin
        rk[127-32*c -: 32] = 32'h0;
      end
    end
  end

  always_comb begin
    st_sub  = abe_pkg::sub_shift(st_q);
    st_next = (round_q == nr) ? st_sub : abe_pkg::mix_columns(st_sub);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      key_size_q   <= abe_pkg::KeySize128;
      keys_ready_q <= 1'b0;
      round_q      <= '0;
      done_q       <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          abe_pkg::RegKeySize: begin
            key_size_q <= cfg_data_i[1:0];
            keys_ready_q <= 1'b0;
          end
          abe_pkg::RegKeyWord0: begin
            key_q[0] <= cfg_data_i;
            keys_ready_q <= 1'b0;
          end
          abe_pkg::RegKeyWord1: begin
            key_q[1] <= cfg_data_i;
            keys_ready_q <= 1'b0;
          end
          abe_pkg::RegKeyWord2: begin
            key_q[2] <= cfg_data_i;
            keys_ready_q <= 1'b0;
          end
          abe_pkg::RegKeyWord3: begin
            key_q[3] <= cfg_data_i;
            keys_ready_q <= 1'b0;
          end
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= keys_ready_q ? StLoad : StExpand;
          end
        end
        StExpand: begin
          if (kx_done) begin
            keys_ready_q <= 1'b1;
            state_q      <= StLoad;
          end
        end
        StLoad: begin
          // Round key 0 is now in rk_q; key 1 is being read.
          round_q <= 4'd1;
          state_q <= StRound;
        end
        StRound: begin
          round_q <= round_q + 4'd1;
          if (round_q == nr) begin
            state_q <= StOut;
          end
        end
        StOut: begin
          done_q  <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // The state word; the first round key is applied in the load cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      st_q <= {text_high_i, text_low_i};
    end else if (state_q == StLoad) begin
      st_q <= st_q ^ rk;
    end else if (state_q == StRound) begin
      st_q <= st_next ^ rk;
    end
  end

  assign busy_o        = (state_q != StIdle);
  assign done_o        = done_q;
  assign cipher_high_o = st_q[127:64];
  assign cipher_low_o  = st_q[63:0];

endmodule

FILE: test/tb_aes_block_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES block encryption testbench
// Drives plaintext blocks under several key sizes and keys, predicts each
// ciphertext with an independent AES model and checks every result in order.
// ----------------------------------------------------------------------------
module tb_aes_block_encrypt;

  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [63:0] text_high_i = '0;
  logic [63:0] text_low_i = '0;
  logic        done_o;
  logic [63:0] cipher_high_o;
  logic [63:0] cipher_low_o;

  aes_block_encrypt u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .start_i(start_i), .busy_o(busy_o),
    .text_high_i(text_high_i), .text_low_i(text_low_i), .done_o(done_o),
    .cipher_high_o(cipher_high_o), .cipher_low_o(cipher_low_o)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: a shadow of the key registers. The key schedule is
  // recomputed for every block, which is cheap and keeps the model simple.
  logic [1:0]  key_sel;
  logic [63:0] key_reg [4];

  logic [127:0] block_queue [$];    // plaintexts waiting for the driver
  logic [127:0] cipher_queue [$];   // ciphertexts expected from the block
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  bit           in_taken = 1'b0;    // a plaintext transfer happened at the last rising edge

  // Our own S-box lookup, built from the GF(2^8) inverse and affine map.
  logic [7:0] sbox_lut [256];

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_double(a);
    end
    return p;
  endfunction

  initial begin
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      end
      s = 8'h63;
      for (int k = 0; k < 5; k++) s ^= (inv << k) | (inv >> (8 - k));
      sbox_lut[x] = s;
    end
  end

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] pt);
    logic [31:0] w [60];
    logic [31:0] col [4];
    logic [31:0] t [4];
    logic [31:0] tmp;
    logic [7:0]  rcon, a0, a1, a2, a3;
    int nk, nr;
    nk = (key_sel == 2'd0) ? 4 : (key_sel == 2'd1) ? 6 : 8;
    nr = nk + 6;
    rcon = 8'h01;
    for (int i = 0; i < nk; i++) begin
      w[i] = i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
    end
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      tmp = w[i-1];
      if (i % nk == 0) begin
        tmp = sbox_word({tmp[23:0], tmp[31:24]}) ^ {rcon, 24'h0};
        rcon = gf_double(rcon);
      end else if (nk == 8 && i % nk == 4) begin
        tmp = sbox_word(tmp);
      end
      w[i] = w[i-nk] ^ tmp;
    end
    for (int c = 0; c < 4; c++) col[c] = pt[127-32*c -: 32] ^ w[c];
    for (int r = 1; r <= nr; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[c] = sbox_word({col[c][31:24], col[(c+1)%4][23:16],
                          col[(c+2)%4][15:8], col[(c+3)%4][7:0]});
      end
      for (int c = 0; c < 4; c++) begin
        if (r < nr) begin
          {a0, a1, a2, a3} = t[c];
          t[c] = {gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3,
                  a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3,
                  a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03),
                  gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02)};
        end
        col[c] = t[c] ^ w[4*r + c];
      end
    end
    return {col[0], col[1], col[2], col[3]};
  endfunction

  // Handshake seen at the rising edge, used by the driver at the next falling edge.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && start_i && !busy_o;
  end

  // Driver: one plaintext transfer per handshake, random gaps between them.
  int unsigned send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        // The current block was taken at the last rising edge.
        cipher_queue.push_back(aes_encrypt({text_high_i, text_low_i}));
        void'(block_queue.pop_front());
        send_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (in_taken || !start_i) begin
        if (send_gap > 0) begin
          send_gap--;
          start_i <= 1'b0;
        end else if (block_queue.size() > 0) begin
          start_i <= 1'b1;
          {text_high_i, text_low_i} <= block_queue[0];
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: a result is present for exactly one cycle, taken at the rising edge.
  always @(posedge clk_i) begin
    logic [127:0] want;
    if (rst_ni && done_o) begin
      if (cipher_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h %h",
                 $time, cipher_high_o, cipher_low_o);
        fail_count++;
      end else begin
        want = cipher_queue.pop_front();
        if (cipher_high_o !== want[127:64]) begin
          $display("%0t: cipher_high mismatch, expected %h, actual %h",
                   $time, want[127:64], cipher_high_o);
          fail_count++;
        end
        if (cipher_low_o !== want[63:0]) begin
          $display("%0t: cipher_low mismatch, expected %h, actual %h",
                   $time, want[63:0], cipher_low_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_aes_block_encrypt failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      abe_pkg::RegKeySize:  key_sel = (data[1:0] == 2'd3) ? 2'd2 : data[1:0];
      abe_pkg::RegKeyWord0: key_reg[0] = data;
      abe_pkg::RegKeyWord1: key_reg[1] = data;
      abe_pkg::RegKeyWord2: key_reg[2] = data;
      abe_pkg::RegKeyWord3: key_reg[3] = data;
      default: ;
    endcase
  endtask

  // Waits until every queued block went in and every result came out.
  task automatic drain();
    while (block_queue.size() > 0 || start_i || busy_o || cipher_queue.size() > 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic load_key(input logic [1:0] sel, input logic [63:0] k0,
                          input logic [63:0] k1, input logic [63:0] k2,
                          input logic [63:0] k3);
    write_reg(abe_pkg::RegKeySize, {62'b0, sel});
    write_reg(abe_pkg::RegKeyWord0, k0);
    write_reg(abe_pkg::RegKeyWord1, k1);
    write_reg(abe_pkg::RegKeyWord2, k2);
    write_reg(abe_pkg::RegKeyWord3, k3);
  endtask

  function automatic logic [63:0] edge_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h0000_0000_0000_0001;
      default: return rand64();
    endcase
  endfunction

  initial begin
    key_sel = 2'd0;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Reset key first: all-zero 128-bit key.
    block_queue.push_back('0);
    block_queue.push_back('1);
    drain();
    // Standard vectors: 128-, 192- and 256-bit keys on the same plaintext.
    load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
    block_queue.push_back(128'h00112233445566778899aabbccddeeff);
    block_queue.push_back(128'h8000_0000_0000_0000_0000_0000_0000_0001);
    drain();
    load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, '1);
    block_queue.push_back(128'h00112233445566778899aabbccddeeff);
    block_queue.push_back('1);
    drain();
    load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    block_queue.push_back(128'h00112233445566778899aabbccddeeff);
    drain();
    // Key size three behaves as a 256-bit key; all-ones key bits.
    load_key(2'd3, '1, '1, '1, '1);
    block_queue.push_back('0);
    block_queue.push_back('1);
    drain();
    // Writes to unused register indexes leave the expanded keys in place.
    write_reg(3'd5, '1);
    write_reg(3'd7, 64'h1234);
    block_queue.push_back(128'h0123456789abcdef_fedcba9876543210);
    drain();
    // A single word rewrite must force a fresh key expansion.
    write_reg(abe_pkg::RegKeyWord3, 64'h0f0e0d0c0b0a0908);
    block_queue.push_back('0);
    drain();

    // Random part: phases with fresh keys and sizes, random plaintexts.
    for (int phase = 0; phase < 20; phase++) begin
      load_key(2'($urandom_range(0, 3)), edge_value(), edge_value(), edge_value(),
               edge_value());
      if ($urandom_range(0, 3) == 0) write_reg(3'($urandom_range(5, 7)), rand64());
      for (int n = 0; n < 20; n++) begin
        if ($urandom_range(0, 7) == 0) block_queue.push_back({edge_value(), edge_value()});
        else block_queue.push_back({rand64(), rand64()});
      end
      drain();
    end

    repeat (40) @(negedge clk_i);
    if (fail_count == 0 && cipher_queue.size() == 0) begin
      $display("tb_aes_block_encrypt passed");
    end else begin
      $display("tb_aes_block_encrypt failed");
    end
    $finish;
  end

endmodule
